### rtl/relay_cycle_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Relay cycle controller assertion macros
// Clocked property wrappers used by the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef RELAY_CYCLE_CONTROLLER_UNIT_ASSERT_SVH
`define RELAY_CYCLE_CONTROLLER_UNIT_ASSERT_SVH

// Property checked at every edge outside reset.
`define RCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// Relay cycle controller package
// Codes, beat layouts and shared helpers for the relay cycle controller.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int unsigned DATA_IN_W  = 104;
  localparam int unsigned DATA_OUT_W = 136;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // input item kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_ENABLE = 3'd1;
  localparam logic [2:0] KIND_POS    = 3'd2;
  localparam logic [2:0] KIND_MODEM  = 3'd3;
  localparam logic [2:0] KIND_RX     = 3'd4;
  localparam logic [2:0] KIND_TARGET = 3'd5;

  // report kinds
  localparam logic [1:0] RK_START  = 2'd0;
  localparam logic [1:0] RK_XMIT   = 2'd1;
  localparam logic [1:0] RK_RESULT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T1          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_T2          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ID     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd5;

  // minus one metre
  localparam logic signed [23:0] NO_POS = -24'sd16;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LINK1 = 2'd1,
    PH_XMIT  = 2'd2,
    PH_LINK2 = 2'd3
  } phase_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        now;
    logic               level;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [7:0]         src_id;
    logic               rx_good;
    logic               ack_len_two;
    logic [7:0]         ack_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        iteration;
    logic               success;
    logic signed [23:0] init_x;
    logic signed [23:0] init_y;
    logic signed [23:0] relay_x;
    logic signed [23:0] relay_y;
    logic signed [24:0] dx0;
    logic signed [24:0] dy0;
    logic signed [24:0] dx1;
    logic signed [24:0] dy1;
    logic [22:0]        radius;
  } report_t;

  function automatic logic [48:0] sq25(input logic signed [24:0] d);
    logic signed [49:0] p;
    p = d * d;
    return p[48:0];
  endfunction

endpackage

### rtl/relay_cycle_controller_unit.sv
// A report beat passes through stage one, stage two and the output register to m_tvalid.
// Throughput: one input beat per cycle unless stalled; the three report stages move with backpressure.
// The range check squares four coordinate offsets in parallel in the middle stage.
// Reset (rst, synchronous): cycle idle, flags and positions zero, configuration zero,
// last cycle time minus one, all report stages empty.
// ----------------------------------------------------------------------------
// Relay cycle controller
// Two-hop relay sequencer with a three-stage report pipeline and range check.
// ----------------------------------------------------------------------------
module relay_cycle_controller_unit
  import rcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now, level, pos_x, pos_y, src_id, rx_good, ack_len_two, ack_byte (low bit up)
  input  logic [DATA_IN_W-1:0]  s_tdata,
  // kind
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // iteration, success, init_x, init_y, relay_x, relay_y, in_radius (low bit up)
  output logic [DATA_OUT_W-1:0] m_tdata,
  // report_kind
  output logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   item;
  logic    accept;
  logic    rep_valid;
  report_t rep;

  // stage one: report with offsets to the target
  logic    valid1;
  report_t rep1;

  // stage two: squared offsets
  logic               valid2;
  logic [1:0]         kind2;
  logic [31:0]        iter2;
  logic               succ2;
  logic signed [23:0] ix2, iy2, rx2, ry2;
  logic [48:0]        sx0, sy0, sx1, sy1;
  logic [45:0]        r2;

  // stage three: output register
  logic               in_radius_q;
  logic [31:0]        iter_q;
  logic               succ_q;
  logic signed [23:0] ix_q, iy_q, rx_q, ry_q;

  logic        out_free, adv2, free2, adv1, free1;
  logic [49:0] d0, d1;
  logic        inrad;

  assign item.kind        = s_tuser;
  assign item.now         = s_tdata[31:0];
  assign item.level       = s_tdata[32];
  assign item.pos_x       = s_tdata[56:33];
  assign item.pos_y       = s_tdata[80:57];
  assign item.src_id      = s_tdata[88:81];
  assign item.rx_good     = s_tdata[89];
  assign item.ack_len_two = s_tdata[90];
  assign item.ack_byte    = s_tdata[98:91];

  assign out_free = !m_tvalid || m_tready;
  assign adv2     = valid2 && out_free;
  assign free2    = !valid2 || adv2;
  assign adv1     = valid1 && free2;
  assign free1    = !valid1 || adv1;
  assign s_tready = free1;
  assign accept   = s_tvalid && s_tready;

  rcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rep_valid (rep_valid),
    .rep       (rep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept && rep_valid) begin
      valid1 <= 1'b1;
    end else if (adv1) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rep_valid) begin
      rep1 <= rep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv1) begin
      valid2 <= 1'b1;
    end else if (adv2) begin
      valid2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      kind2 <= rep1.kind;
      iter2 <= rep1.iteration;
      succ2 <= rep1.success;
      ix2   <= rep1.init_x;
      iy2   <= rep1.init_y;
      rx2   <= rep1.relay_x;
      ry2   <= rep1.relay_y;
      sx0   <= sq25(rep1.dx0);
      sy0   <= sq25(rep1.dy0);
      sx1   <= sq25(rep1.dx1);
      sy1   <= sq25(rep1.dy1);
      r2    <= rep1.radius * rep1.radius;
    end
  end

  assign d0    = {1'b0, sx0} + {1'b0, sy0};
  assign d1    = {1'b0, sx1} + {1'b0, sy1};
  assign inrad = (kind2 == RK_RESULT) && (d0 < {4'd0, r2}) && (d1 < {4'd0, r2});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      m_tuser     <= kind2;
      iter_q      <= iter2;
      succ_q      <= succ2;
      ix_q        <= ix2;
      iy_q        <= iy2;
      rx_q        <= rx2;
      ry_q        <= ry2;
      in_radius_q <= inrad;
    end
  end

  assign m_tdata = {6'd0, in_radius_q, ry_q, rx_q, iy_q, ix_q, succ_q, iter_q};

endmodule

### rtl/rcc_core.sv
// ----------------------------------------------------------------------------
// Relay cycle controller core
// Configuration registers, event state and the four-phase cycle sequencer.
// ----------------------------------------------------------------------------
module rcc_core
  import rcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  item_t                 item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  rep_valid,
  output report_t               rep
);

  logic [31:0] hop_delay, first_link_timeout, second_link_timeout;
  logic [7:0]  source_id, dest_id;
  logic [22:0] radius;

  phase_t             phase, phase_next;
  logic               enabled, enabled_next;
  logic               modem_ready, modem_ready_next;
  logic signed [23:0] cur_x, cur_x_next, cur_y, cur_y_next;
  logic signed [23:0] target_x, target_x_next, target_y, target_y_next;
  logic signed [32:0] last_time, last_time_next;
  logic [31:0]        cycle_count, cycle_count_next;
  logic signed [23:0] start_x, start_x_next, start_y, start_y_next;
  logic signed [23:0] hop_x, hop_x_next, hop_y, hop_y_next;
  logic               got_trans, got_trans_next, trans_good, trans_good_next;
  logic               got_ack, got_ack_next, ack_good, ack_good_next;

  logic [31:0]        delay_sel;
  logic signed [33:0] limit;
  logic               later;
  logic               tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_delay           <= '0;
      first_link_timeout  <= '0;
      second_link_timeout <= '0;
      source_id           <= '0;
      dest_id             <= '0;
      radius              <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOP_DELAY:   hop_delay           <= cfg_data;
        CFG_T1:          first_link_timeout  <= cfg_data;
        CFG_T2:          second_link_timeout <= cfg_data;
        CFG_SOURCE_ID:   source_id           <= cfg_data[7:0];
        CFG_DEST_ID:     dest_id             <= cfg_data[7:0];
        CFG_RADIUS:      radius              <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase)
      PH_LINK1: delay_sel = first_link_timeout;
      PH_LINK2: delay_sel = second_link_timeout;
      default:  delay_sel = hop_delay;
    endcase
  end

  // last_time may be minus one, so compare on a signed 34-bit range
  assign limit = {last_time[32], last_time} + $signed({2'b00, delay_sel});
  assign later = $signed({2'b00, item.now}) > limit;
  assign tick  = accept && (item.kind == KIND_TICK);

  always_comb begin
    phase_next = phase;
    if (tick) begin
      case (phase)
        PH_IDLE:  if (enabled && later) phase_next = PH_LINK1;
        PH_LINK1: begin
          if (got_trans) phase_next = trans_good ? PH_XMIT : PH_IDLE;
          else if (later) phase_next = PH_IDLE;
        end
        PH_XMIT:  if (modem_ready && later) phase_next = PH_LINK2;
        PH_LINK2: if (got_ack || later) phase_next = PH_IDLE;
        default:  phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    enabled_next     = enabled;
    modem_ready_next = modem_ready;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    last_time_next   = last_time;
    cycle_count_next = cycle_count;
    start_x_next     = start_x;
    start_y_next     = start_y;
    hop_x_next       = hop_x;
    hop_y_next       = hop_y;
    got_trans_next   = got_trans;
    trans_good_next  = trans_good;
    got_ack_next     = got_ack;
    ack_good_next    = ack_good;
    rep_valid        = 1'b0;
    rep              = '0;

    if (tick) begin
      case (phase)
        PH_IDLE: begin
          start_x_next = NO_POS;
          start_y_next = NO_POS;
          hop_x_next   = NO_POS;
          hop_y_next   = NO_POS;
          if (enabled && later) begin
            start_x_next     = cur_x;
            start_y_next     = cur_y;
            rep_valid        = 1'b1;
            rep.kind         = RK_START;
            cycle_count_next = cycle_count + 32'd1;
            got_trans_next   = 1'b0;
            last_time_next   = {1'b0, item.now};
          end
        end
        PH_LINK1: begin
          if (got_trans) begin
            last_time_next = {1'b0, item.now};
            if (!trans_good) begin
              rep_valid = 1'b1;
              rep.kind  = RK_RESULT;
            end
          end else if (later) begin
            last_time_next = {1'b0, item.now};
            rep_valid      = 1'b1;
            rep.kind       = RK_RESULT;
          end
        end
        PH_XMIT: begin
          if (modem_ready && later) begin
            hop_x_next     = cur_x;
            hop_y_next     = cur_y;
            rep_valid      = 1'b1;
            rep.kind       = RK_XMIT;
            got_ack_next   = 1'b0;
            last_time_next = {1'b0, item.now};
          end
        end
        default: begin
          if (got_ack || later) begin
            last_time_next = {1'b0, item.now};
            rep_valid      = 1'b1;
            rep.kind       = RK_RESULT;
            rep.success    = got_ack && ack_good;
          end
        end
      endcase
    end else if (accept) begin
      case (item.kind)
        KIND_ENABLE: enabled_next = item.level;
        KIND_POS: begin
          cur_x_next = item.pos_x;
          cur_y_next = item.pos_y;
        end
        KIND_MODEM: modem_ready_next = item.level;
        KIND_RX: begin
          // the source match wins over the destination match
          if (item.src_id == source_id) begin
            got_trans_next  = 1'b1;
            trans_good_next = item.rx_good;
          end else if (item.src_id == dest_id) begin
            got_ack_next  = 1'b1;
            ack_good_next = item.ack_len_two && (item.ack_byte == 8'd0);
          end
        end
        KIND_TARGET: begin
          target_x_next = item.pos_x;
          target_y_next = item.pos_y;
        end
        default: ;
      endcase
    end

    rep.iteration = cycle_count;
    rep.init_x    = start_x_next;
    rep.init_y    = start_y_next;
    rep.relay_x   = hop_x_next;
    rep.relay_y   = hop_y_next;
    rep.dx0       = {start_x_next[23], start_x_next} - {target_x[23], target_x};
    rep.dy0       = {start_y_next[23], start_y_next} - {target_y[23], target_y};
    rep.dx1       = {hop_x_next[23], hop_x_next} - {target_x[23], target_x};
    rep.dy1       = {hop_y_next[23], hop_y_next} - {target_y[23], target_y};
    rep.radius    = radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      enabled     <= 1'b0;
      modem_ready <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      last_time   <= '1;
      cycle_count <= '0;
      start_x     <= '0;
      start_y     <= '0;
      hop_x       <= '0;
      hop_y       <= '0;
      got_trans   <= 1'b0;
      trans_good  <= 1'b0;
      got_ack     <= 1'b0;
      ack_good    <= 1'b0;
    end else begin
      phase       <= phase_next;
      enabled     <= enabled_next;
      modem_ready <= modem_ready_next;
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      last_time   <= last_time_next;
      cycle_count <= cycle_count_next;
      start_x     <= start_x_next;
      start_y     <= start_y_next;
      hop_x       <= hop_x_next;
      hop_y       <= hop_y_next;
      got_trans   <= got_trans_next;
      trans_good  <= trans_good_next;
      got_ack     <= got_ack_next;
      ack_good    <= ack_good_next;
    end
  end

endmodule

### rtl/rcc_checker.sv
// ----------------------------------------------------------------------------
// Relay cycle controller checker
// Port-level checks on the report stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "relay_cycle_controller_unit_assert.svh"

module rcc_checker
  import rcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [DATA_OUT_W-1:0] m_tdata,
  input logic [1:0]            m_tuser
);

  // a stalled beat holds
  `RCC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "report beat changed while stalled")

  // only a result carries success or the in-radius flag
  `RCC_ASSERT(a_flags, m_tvalid && m_tuser != RK_RESULT |-> !m_tdata[32] && !m_tdata[129], "flags set on a non-result report")

  // a start report has never relayed
  `RCC_ASSERT(a_start_relay, m_tvalid && m_tuser == RK_START |-> m_tdata[104:81] == NO_POS && m_tdata[128:105] == NO_POS, "start report with a relay position")

  // no report straight out of reset
  `RCC_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid, "report beat offered after reset")

endmodule

bind relay_cycle_controller_unit rcc_checker u_rcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/sv/relay_report_checker.sv
// ----------------------------------------------------------------------------
// Relay cycle report checker
// Watches the item, report and register ports of the relay cycle controller,
// keeps its own copy of the cycle state and registers, works out the report
// each accepted item should cause and compares every report field by field.
// ----------------------------------------------------------------------------
module relay_report_checker
  import rcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // now, level, pos_x, pos_y, src_id, rx_good, ack_len_two, ack_byte (low bit up)
  input  logic [DATA_IN_W-1:0]  s_tdata,
  // kind
  input  logic [2:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // iteration, success, init_x, init_y, relay_x, relay_y, in_radius (low bit up)
  input  logic [DATA_OUT_W-1:0] m_tdata,
  // report_kind
  input  logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           pending
);

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        iteration;
    logic               success;
    logic signed [23:0] init_x;
    logic signed [23:0] init_y;
    logic signed [23:0] relay_x;
    logic signed [23:0] relay_y;
    logic               in_radius;
  } rpt_t;

  rpt_t due_reports[$];
  int unsigned errors = 0;
  int unsigned rpt_no = 0;

  // register copies
  logic [31:0] reg_delay, reg_t1, reg_t2;
  logic [7:0]  reg_src, reg_dst;
  logic [22:0] reg_radius;

  // cycle state
  phase_t             cyc_phase;
  logic               enabled, modem_ready;
  logic signed [23:0] cur_x, cur_y, tgt_x, tgt_y;
  logic signed [32:0] last_stamp;
  logic [31:0]        cycle_count;
  logic signed [23:0] start_x, start_y, hop_x, hop_y;
  logic               got_trans, trans_good, got_ack, ack_good;

  task automatic note_failure(input string msg);
    $display("%0t: report %0d: %s", $time, rpt_no, msg);
    errors++;
  endtask

  // no wrap: 35-bit signed sum of a 33-bit stamp and a 32-bit wait
  function automatic logic time_passed(input logic [31:0] now, input logic [31:0] wait_ms);
    logic signed [34:0] lhs, rhs;
    lhs = $signed({3'b000, now});
    rhs = $signed({{2{last_stamp[32]}}, last_stamp}) + $signed({3'b000, wait_ms});
    return lhs > rhs;
  endfunction

  function automatic logic near_target(input logic signed [23:0] x, input logic signed [23:0] y);
    logic signed [24:0] dx, dy;
    logic [24:0]        ax, ay;
    logic [49:0]        d2, r2;
    dx = $signed({x[23], x}) - $signed({tgt_x[23], tgt_x});
    dy = $signed({y[23], y}) - $signed({tgt_y[23], tgt_y});
    ax = dx[24] ? -dx : dx;
    ay = dy[24] ? -dy : dy;
    d2 = 50'(ax) * 50'(ax) + 50'(ay) * 50'(ay);
    r2 = 50'(reg_radius) * 50'(reg_radius);
    return d2 < r2;
  endfunction

  task automatic queue_report(input logic [1:0] k, input logic ok, input logic inr);
    rpt_t r;
    r.kind      = k;
    r.iteration = cycle_count;
    r.success   = ok;
    r.init_x    = start_x;
    r.init_y    = start_y;
    r.relay_x   = hop_x;
    r.relay_y   = hop_y;
    r.in_radius = inr;
    due_reports.push_back(r);
  endtask

  task automatic queue_result(input logic ok);
    queue_report(RK_RESULT, ok, near_target(start_x, start_y) && near_target(hop_x, hop_y));
    cyc_phase = PH_IDLE;
  endtask

  task automatic run_tick(input logic [31:0] now);
    case (cyc_phase)
      PH_IDLE: begin
        start_x = NO_POS;
        start_y = NO_POS;
        hop_x   = NO_POS;
        hop_y   = NO_POS;
        if (enabled && time_passed(now, reg_delay)) begin
          start_x = cur_x;
          start_y = cur_y;
          queue_report(RK_START, 1'b0, 1'b0);
          cycle_count++;
          got_trans  = 1'b0;
          cyc_phase  = PH_LINK1;
          last_stamp = {1'b0, now};
        end
      end
      PH_LINK1: begin
        if (got_trans) begin
          if (trans_good) cyc_phase = PH_XMIT;
          else queue_result(1'b0);
          last_stamp = {1'b0, now};
        end else if (time_passed(now, reg_t1)) begin
          queue_result(1'b0);
          last_stamp = {1'b0, now};
        end
      end
      PH_XMIT: begin
        if (modem_ready && time_passed(now, reg_delay)) begin
          hop_x = cur_x;
          hop_y = cur_y;
          queue_report(RK_XMIT, 1'b0, 1'b0);
          got_ack    = 1'b0;
          cyc_phase  = PH_LINK2;
          last_stamp = {1'b0, now};
        end
      end
      default: begin
        if (got_ack) begin
          queue_result(ack_good);
          last_stamp = {1'b0, now};
        end else if (time_passed(now, reg_t2)) begin
          queue_result(1'b0);
          last_stamp = {1'b0, now};
        end
      end
    endcase
  endtask

  task automatic apply_item(input item_t it);
    case (it.kind)
      KIND_TICK:   run_tick(it.now);
      KIND_ENABLE: enabled = it.level;
      KIND_POS: begin
        cur_x = it.pos_x;
        cur_y = it.pos_y;
      end
      KIND_MODEM:  modem_ready = it.level;
      KIND_RX: begin
        // source id wins when both ids match
        if (it.src_id == reg_src) begin
          got_trans  = 1'b1;
          trans_good = it.rx_good;
        end else if (it.src_id == reg_dst) begin
          got_ack  = 1'b1;
          ack_good = it.ack_len_two && (it.ack_byte == 8'h00);
        end
      end
      KIND_TARGET: begin
        tgt_x = it.pos_x;
        tgt_y = it.pos_y;
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_HOP_DELAY:   reg_delay  = val;
      CFG_T1:          reg_t1     = val;
      CFG_T2:          reg_t2     = val;
      CFG_SOURCE_ID:   reg_src    = val[7:0];
      CFG_DEST_ID:     reg_dst    = val[7:0];
      CFG_RADIUS:      reg_radius = val[22:0];
      default: ;
    endcase
  endtask

  task automatic check_report();
    rpt_t got, want;
    got.kind      = m_tuser;
    got.iteration = m_tdata[31:0];
    got.success   = m_tdata[32];
    got.init_x    = m_tdata[56:33];
    got.init_y    = m_tdata[80:57];
    got.relay_x   = m_tdata[104:81];
    got.relay_y   = m_tdata[128:105];
    got.in_radius = m_tdata[129];
    rpt_no++;
    if (due_reports.size() == 0) begin
      note_failure($sformatf("report_kind %0d arrived with nothing due", got.kind));
    end else begin
      want = due_reports.pop_front();
      if (got.kind !== want.kind)
        note_failure($sformatf("report_kind got %0d want %0d", got.kind, want.kind));
      if (got.iteration !== want.iteration)
        note_failure($sformatf("iteration got %0d want %0d", got.iteration, want.iteration));
      if (got.success !== want.success)
        note_failure($sformatf("success got %0d want %0d", got.success, want.success));
      if (got.init_x !== want.init_x)
        note_failure($sformatf("init_x got %0d want %0d", got.init_x, want.init_x));
      if (got.init_y !== want.init_y)
        note_failure($sformatf("init_y got %0d want %0d", got.init_y, want.init_y));
      if (got.relay_x !== want.relay_x)
        note_failure($sformatf("relay_x got %0d want %0d", got.relay_x, want.relay_x));
      if (got.relay_y !== want.relay_y)
        note_failure($sformatf("relay_y got %0d want %0d", got.relay_y, want.relay_y));
      if (got.in_radius !== want.in_radius)
        note_failure($sformatf("in_radius got %0d want %0d", got.in_radius, want.in_radius));
    end
  endtask

  always @(posedge clk) begin
    item_t it;
    if (rst) begin
      reg_delay   = '0;
      reg_t1      = '0;
      reg_t2      = '0;
      reg_src     = '0;
      reg_dst     = '0;
      reg_radius  = '0;
      cyc_phase   = PH_IDLE;
      enabled     = 1'b0;
      modem_ready = 1'b0;
      cur_x       = '0;
      cur_y       = '0;
      tgt_x       = '0;
      tgt_y       = '0;
      last_stamp  = -33'sd1;
      cycle_count = '0;
      start_x     = '0;
      start_y     = '0;
      hop_x       = '0;
      hop_y       = '0;
      got_trans   = 1'b0;
      trans_good  = 1'b0;
      got_ack     = 1'b0;
      ack_good    = 1'b0;
      due_reports.delete();
    end else begin
      // retire the report first: it always belongs to an older item
      if (m_tvalid && m_tready) check_report();
      if (cfg_we) write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        it.kind        = s_tuser;
        it.now         = s_tdata[31:0];
        it.level       = s_tdata[32];
        it.pos_x       = s_tdata[56:33];
        it.pos_y       = s_tdata[80:57];
        it.src_id      = s_tdata[88:81];
        it.rx_good     = s_tdata[89];
        it.ack_len_two = s_tdata[90];
        it.ack_byte    = s_tdata[98:91];
        apply_item(it);
      end
    end
    fail_count <= errors;
    pending    <= due_reports.size();
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Relay cycle controller testbench
// Drives event and tick beats through directed relay cycles, then random
// cycles under several register settings with random gaps and stalls; the
// report checker beside the block judges every report beat.
// ----------------------------------------------------------------------------
module tb;
  import rcc_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_IN_W-1:0]  s_tdata = '0;
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_OUT_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           fail_count;
  int unsigned           pending;

  // stimulus side copies of the settings, used only to shape cycles
  logic [31:0]        ms = '0;
  logic [31:0]        dly = '0, to1 = '0, to2 = '0;
  logic [7:0]         sid = '0, did = '0;
  logic [22:0]        rad = '0;
  logic signed [23:0] tgt_x = '0, tgt_y = '0;
  int unsigned        sent = 0;
  int unsigned        sink_hold = 0;
  bit                 quiet = 1'b0;

  always #5 clk = ~clk;

  relay_cycle_controller_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  relay_report_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // report sink: draw a random wait, none while quiet, for every beat
  always @(posedge clk) begin
    int unsigned w;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      if (sink_hold == 1) m_tready <= 1'b1;
    end else if (!m_tready || m_tvalid) begin
      w = quiet ? 0 : $urandom_range(0, 5);
      if (w == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready  <= 1'b0;
        sink_hold <= w;
      end
    end
  end

  function automatic item_t mk_item(input logic [2:0] k);
    item_t it;
    it.kind        = k;
    it.now         = $urandom;
    it.level       = 1'($urandom);
    it.pos_x       = 24'($urandom);
    it.pos_y       = 24'($urandom);
    it.src_id      = 8'($urandom);
    it.rx_good     = 1'($urandom);
    it.ack_len_two = 1'($urandom);
    it.ack_byte    = 8'($urandom);
    return it;
  endfunction

  // offset around a target point, mostly within reach of the radius
  function automatic logic signed [23:0] near(input logic signed [23:0] c);
    int unsigned span;
    int          v;
    span = (rad < 23'd2097152) ? rad + 16 : 2097152;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - int'(span);
    return v[23:0];
  endfunction

  task automatic send(input item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {5'd0, it.ack_byte, it.ack_len_two, it.rx_good, it.src_id,
                 it.pos_y, it.pos_x, it.level, it.now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // hold off until every report has come, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] d, input logic [31:0] t1, input logic [31:0] t2,
                           input logic [7:0] s, input logic [7:0] r, input logic [22:0] rr);
    dly = d;
    to1 = t1;
    to2 = t2;
    sid = s;
    did = r;
    rad = rr;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOP_DELAY;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= CFG_T1;
    cfg_data  <= t1;
    @(posedge clk);
    cfg_index <= CFG_T2;
    cfg_data  <= t2;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_ID;
    cfg_data  <= {24'd0, s};
    @(posedge clk);
    cfg_index <= CFG_DEST_ID;
    cfg_data  <= {24'd0, r};
    @(posedge clk);
    cfg_index <= CFG_RADIUS;
    cfg_data  <= {9'd0, rr};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic tick_at(input logic [31:0] t);
    item_t it;
    it = mk_item(KIND_TICK);
    it.now = t;
    send(it);
  endtask

  task automatic set_level(input logic [2:0] k, input logic lv);
    item_t it;
    it = mk_item(k);
    it.level = lv;
    send(it);
  endtask

  task automatic set_xy(input logic [2:0] k, input logic signed [23:0] x,
                        input logic signed [23:0] y);
    item_t it;
    it = mk_item(k);
    it.pos_x = x;
    it.pos_y = y;
    if (k == KIND_TARGET) begin
      tgt_x = x;
      tgt_y = y;
    end
    send(it);
  endtask

  task automatic hear(input logic [7:0] src, input logic good, input logic len2,
                      input logic [7:0] ab);
    item_t it;
    it = mk_item(KIND_RX);
    it.src_id      = src;
    it.rx_good     = good;
    it.ack_len_two = len2;
    it.ack_byte    = ab;
    send(it);
  endtask

  task automatic aim();
    set_xy(KIND_TARGET, 24'($signed($urandom_range(0, 8388608)) - 4194304),
           24'($signed($urandom_range(0, 8388608)) - 4194304));
  endtask

  task automatic noise();
    item_t it;
    it = mk_item(3'($urandom_range(0, 7)));
    if (it.kind == KIND_TICK) begin
      it.now = ms + $urandom_range(0, 8);
    end else if (it.kind == KIND_RX) begin
      case ($urandom_range(0, 2))
        0: it.src_id = sid;
        1: it.src_id = did;
        default: ;
      endcase
    end else if (it.kind == KIND_TARGET) begin
      tgt_x = it.pos_x;
      tgt_y = it.pos_y;
    end
    send(it);
  endtask

  // one well-formed cycle with random content and the odd stray beat
  task automatic relay_round();
    int unsigned pick;
    if ($urandom_range(0, 3) == 0) aim();
    set_xy(KIND_POS, near(tgt_x), near(tgt_y));
    set_level(KIND_ENABLE, $urandom_range(0, 9) != 0);
    ms = ms + dly + 32'd1 + $urandom_range(0, 3);
    tick_at(ms);
    if ($urandom_range(0, 2) == 0) noise();
    pick = $urandom_range(0, 5);
    if (pick <= 4) begin
      hear(sid, pick <= 3, 1'($urandom), 8'($urandom));
      ms = ms + $urandom_range(0, 2);
    end else begin
      if ($urandom_range(0, 1) == 0) hear(8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      ms = ms + to1 + 32'd1;
    end
    tick_at(ms);
    set_xy(KIND_POS, near(tgt_x), near(tgt_y));
    set_level(KIND_MODEM, $urandom_range(0, 9) != 0);
    ms = ms + dly + 32'd1 + $urandom_range(0, 2);
    tick_at(ms);
    if ($urandom_range(0, 2) == 0) noise();
    pick = $urandom_range(0, 5);
    case (pick)
      0, 1, 2: hear(did, 1'($urandom), 1'b1, 8'h00);
      3:       hear(did, 1'($urandom), 1'b1, 8'($urandom_range(1, 255)));
      4:       hear(did, 1'($urandom), 1'b0, 8'($urandom_range(0, 1)));
      default: ms = ms + to2 + 32'd1;
    endcase
    ms = ms + $urandom_range(0, 2);
    tick_at(ms);
    if ($urandom_range(0, 3) == 0) tick_at(ms);
  endtask

  task automatic random_phase(input int unsigned p, input int unsigned quota);
    int unsigned stop;
    logic [31:0] base;
    // move the clock up a step so the high time bits see both values
    base = p * 32'h2492_4924 + $urandom_range(0, 1 << 24);
    if (base > ms) ms = base;
    stop = sent + quota;
    aim();
    while (sent < stop) begin
      if ($urandom_range(0, 3) == 0) noise();
      else relay_round();
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      if ($urandom_range(0, 39) == 0) settle();
    end
    settle();
  endtask

  task automatic random_regs();
    logic [7:0] s;
    s = 8'($urandom);
    load_regs($urandom_range(0, 6), $urandom_range(0, 25), $urandom_range(0, 25), s,
              ($urandom_range(0, 3) == 0) ? s : 8'($urandom),
              ($urandom_range(0, 1) == 0) ? 23'($urandom_range(0, 4000)) : 23'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // longest relay delay straight after reset: a tick one short must not start
    load_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 8'h00, 8'hFF, 23'h7F_FFFF);
    tick_at(32'd0);
    set_level(KIND_ENABLE, 1'b1);
    tick_at(32'hFFFF_FFFE);
    send(mk_item(KIND_SPARE_A));
    send(mk_item(KIND_SPARE_B));
    set_xy(KIND_POS, 24'sh7F_FFFF, 24'sh80_0000);
    set_xy(KIND_TARGET, 24'sh80_0000, 24'sh7F_FFFF);
    settle();

    // full cycle driven by receptions, corner positions, early and bad receptions
    load_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h05, 8'h06, 23'h7F_FFFF);
    tick_at(32'd0);
    hear(8'h05, 1'b1, 1'b0, 8'hFF);
    set_xy(KIND_POS, 24'sh80_0000, 24'sh7F_FFFF);
    tick_at(32'd0);
    set_level(KIND_MODEM, 1'b1);
    tick_at(32'd0);
    tick_at(32'd1);
    hear(8'h09, 1'b1, 1'b1, 8'h00);
    tick_at(32'd2);
    hear(8'h06, 1'b0, 1'b1, 8'h00);
    tick_at(32'd3);
    tick_at(32'd3);
    tick_at(32'd4);
    hear(8'h06, 1'b1, 1'b1, 8'h80);
    tick_at(32'd4);
    hear(8'h05, 1'b0, 1'b1, 8'h00);
    tick_at(32'd5);
    settle();

    random_regs();
    random_phase(1, 300);
    // all zero: zero radius, equal ids, immediate timeouts
    load_regs(32'd0, 32'd0, 32'd0, 8'h00, 8'h00, 23'd0);
    random_phase(2, 250);
    // widest timeouts, top ids, largest radius
    load_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 23'h7F_FFFF);
    random_phase(3, 250);
    random_regs();
    random_phase(4, 330);
    random_regs();
    random_phase(5, 330);
    random_regs();
    random_phase(6, 330);

    tick_at(32'hFFFF_FFFF);
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/rcc_pkg.sv
rtl/rcc_core.sv
rtl/relay_cycle_controller_unit.sv
rtl/rcc_checker.sv
tb/sv/relay_report_checker.sv
tb/sv/tb.sv
